// ----- rtl/core/ctc_pkg.sv -----
// Package for the cook timer countdown block.
// Shared types and constants; no dependencies.
`timescale 1ns / 1ps

package ctc_pkg;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned MsW      = 16;
  localparam int unsigned DigitW   = 4;
  localparam int unsigned SecW     = 6;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegRepeatInterval = 2'd0;
  localparam logic [CfgIdxW-1:0] RegSecondLength   = 2'd1;

  localparam logic [MsW-1:0] RepeatIntervalRst = 16'd100;
  localparam logic [MsW-1:0] SecondLengthRst   = 16'd1000;
  localparam logic [MsW-1:0] MsMax             = 16'hFFFF;

  localparam logic [DigitW:0] DigitLimit = 5'd10;
  localparam logic [DigitW-1:0] DigitMax = 4'd9;
  localparam logic [SecW:0] SecLimit     = 7'd60;
  localparam logic [SecW:0] SecStep      = 7'd10;
  localparam logic [SecW-1:0] SecMax     = 6'd59;

  typedef struct packed {
    logic [MsW-1:0] repeat_interval_ms;
    logic [MsW-1:0] second_length_ms;
  } cfg_t;

  typedef struct packed {
    logic start_pressed;
    logic stop_pressed;
    logic ten_min_pressed;
    logic min_pressed;
    logic ten_sec_pressed;
  } tick_t;

  // Input stage contents handed to the timer core
  typedef struct packed {
    logic  valid;
    tick_t tick;
  } stage_t;

endpackage

// ----- rtl/core/ctc_if.sv -----
// Channel interfaces for the cook timer countdown block.
// No dependencies.
`timescale 1ns / 1ps

interface ctc_tick_if;
  logic valid;
  logic ready;
  logic start_pressed;
  logic stop_pressed;
  logic ten_min_pressed;
  logic min_pressed;
  logic ten_sec_pressed;

  modport source (output valid, start_pressed, stop_pressed, ten_min_pressed,
                  min_pressed, ten_sec_pressed, input ready);
  modport sink (input valid, start_pressed, stop_pressed, ten_min_pressed,
                min_pressed, ten_sec_pressed, output ready);
endinterface

interface ctc_result_if;
  logic       valid;
  logic       ready;
  logic       running;
  logic [3:0] tens_of_minutes;
  logic [3:0] minutes_digit;
  logic [5:0] seconds_value;

  modport source (output valid, running, tens_of_minutes, minutes_digit, seconds_value,
                  input ready);
  modport sink (input valid, running, tens_of_minutes, minutes_digit, seconds_value,
                output ready);
endinterface

interface ctc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/core/ctc_cfg_regs.sv -----
// Configuration registers of the cook timer countdown block.
// Depends on ctc_pkg and ctc_cfg_if.
`timescale 1ns / 1ps

module ctc_cfg_regs import ctc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  ctc_cfg_if.sink    cfg_i,
  output cfg_t       cfg_o
);

  logic [MsW-1:0] repeat_q, repeat_d;
  logic [MsW-1:0] second_q, second_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    repeat_d = repeat_q;
    second_d = second_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        RegRepeatInterval: repeat_d = cfg_i.data;
        RegSecondLength:   second_d = cfg_i.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      repeat_q <= RepeatIntervalRst;
      second_q <= SecondLengthRst;
    end else begin
      repeat_q <= repeat_d;
      second_q <= second_d;
    end
  end

  assign cfg_o.repeat_interval_ms = repeat_q;
  assign cfg_o.second_length_ms   = second_q;

endmodule

// ----- rtl/core/ctc_in_reg.sv -----
// Input register stage of the cook timer countdown block.
// Depends on ctc_pkg and ctc_tick_if.
`timescale 1ns / 1ps

module ctc_in_reg import ctc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  ctc_tick_if.sink tick_i,
  input  logic     advance_i,   // core takes the stage this cycle
  output stage_t   stage_o
);

  logic  valid_q, valid_d;
  tick_t tick_q;
  logic  load;

  assign tick_i.ready = !valid_q || advance_i;
  assign load         = tick_i.valid && tick_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      tick_q.start_pressed   <= tick_i.start_pressed;
      tick_q.stop_pressed    <= tick_i.stop_pressed;
      tick_q.ten_min_pressed <= tick_i.ten_min_pressed;
      tick_q.min_pressed     <= tick_i.min_pressed;
      tick_q.ten_sec_pressed <= tick_i.ten_sec_pressed;
    end
  end

  assign stage_o.valid = valid_q;
  assign stage_o.tick  = tick_q;

endmodule

// ----- rtl/core/ctc_timer_core.sv -----
// Timer state, per-tick update logic and result register.
// Depends on ctc_pkg and ctc_result_if.
`timescale 1ns / 1ps

module ctc_timer_core import ctc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  stage_t      stage_i,
  output logic        advance_o,
  ctc_result_if.source result_o
);

  logic              run_q, run_d;
  logic [DigitW-1:0] tens_q, tens_d;
  logic [DigitW-1:0] min_q, min_d;
  logic [SecW-1:0]   sec_q, sec_d;
  logic [MsW-1:0]    el_q, el_d;
  logic              out_valid_q, out_valid_d;

  logic [MsW-1:0]    el_inc;
  logic [DigitW:0]   tens_bump, min_bump;
  logic [SecW:0]     sec_bump;
  logic              any_set;
  logic              time_zero;

  assign advance_o = stage_i.valid && (!out_valid_q || result_o.ready);

  always_comb begin
    el_inc    = (el_q != MsMax) ? el_q + 1'b1 : el_q;
    any_set   = stage_i.tick.ten_min_pressed || stage_i.tick.min_pressed ||
                stage_i.tick.ten_sec_pressed;

    run_d  = run_q;
    tens_d = tens_q;
    min_d  = min_q;
    sec_d  = sec_q;
    el_d   = el_inc;

    if (stage_i.tick.start_pressed) begin
      run_d = 1'b1;
    end else if (stage_i.tick.stop_pressed) begin
      run_d  = 1'b0;
      tens_d = '0;
      min_d  = '0;
      sec_d  = '0;
    end

    // time as left by a stop press
    time_zero = (tens_d == '0) && (min_d == '0) && (sec_d == '0);

    // set buttons act on the time as left by a stop press
    tens_bump = {1'b0, tens_d} + 1'b1;
    min_bump  = {1'b0, min_d} + 1'b1;
    sec_bump  = {1'b0, sec_d} + SecStep;

    if (!run_q) begin
      if (any_set && (el_inc >= cfg_i.repeat_interval_ms)) begin
        el_d = '0;
        if (stage_i.tick.ten_min_pressed) begin
          tens_d = (tens_bump >= DigitLimit) ? '0 : tens_bump[DigitW-1:0];
        end else if (stage_i.tick.min_pressed) begin
          min_d = (min_bump >= DigitLimit) ? '0 : min_bump[DigitW-1:0];
        end else begin
          sec_d = (sec_bump >= SecLimit) ? '0 : sec_bump[SecW-1:0];
        end
      end
    end else begin
      if (time_zero) begin
        run_d = 1'b0;
      end else if (el_inc >= cfg_i.second_length_ms) begin
        el_d = '0;
        if (sec_q != '0) begin
          sec_d = sec_q - 1'b1;
        end else begin
          sec_d = SecMax;
          if (min_q != '0) begin
            min_d = min_q - 1'b1;
          end else begin
            min_d  = DigitMax;
            tens_d = tens_q - 1'b1;
          end
        end
      end
    end

    out_valid_d = out_valid_q;
    if (advance_o) begin
      out_valid_d = 1'b1;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q       <= 1'b0;
      tens_q      <= '0;
      min_q       <= '0;
      sec_q       <= '0;
      el_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (advance_o) begin
        run_q  <= run_d;
        tens_q <= tens_d;
        min_q  <= min_d;
        sec_q  <= sec_d;
        el_q   <= el_d;
      end
    end
  end

  // state registers double as the result register
  assign result_o.valid           = out_valid_q;
  assign result_o.running         = run_q;
  assign result_o.tens_of_minutes = tens_q;
  assign result_o.minutes_digit   = min_q;
  assign result_o.seconds_value   = sec_q;

  a_state_held_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !result_o.ready |=> $stable(run_q) && $stable(tens_q) &&
                                       $stable(min_q) && $stable(sec_q) && $stable(el_q))
    else $error("timer state changed while result stalled");

  a_digits_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tens_q <= DigitMax) && (min_q <= DigitMax) && (sec_q <= SecMax))
    else $error("time digit out of range");

  a_zero_time_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_o && run_q && (tens_q == '0) && (min_q == '0) && (sec_q == '0)
    |=> !run_q)
    else $error("running with zero time did not stop");

  a_result_after_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_o |=> out_valid_q)
    else $error("tick consumed without a result");

endmodule

// ----- rtl/core/cook_timer_countdown.sv -----
// Top level of the cook timer countdown block.
// Depends on ctc_pkg, the ctc interfaces, ctc_cfg_regs, ctc_in_reg, ctc_timer_core.
`timescale 1ns / 1ps

// Microwave-style cook timer. Each transaction on tick_i is one millisecond
// tick carrying the five button levels; each tick yields exactly one
// transaction on result_o with the run flag and the time after that tick.
// cfg_i writes the repeat interval (index 0) and the second length (index 1);
// it is always ready and should be used only while no tick is in flight.
// A tick passes through two register stages: the input register, then the
// state/result register.
// Throughput: one tick per cycle while result_o does not stall; the update is
// one compare/increment pass over the state registers.
// Reset clears the run flag, the time and the millisecond counter and loads
// the configuration reset values (100 ms repeat, 1000 ms second). No clearing
// pass is needed; ticks are taken as soon as reset is released.
// When result_o stalls, the state holds; the input register still takes one
// more tick, after which tick_i.ready drops until the result is taken.

module cook_timer_countdown import ctc_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  ctc_cfg_if.sink       cfg_i,
  ctc_tick_if.sink      tick_i,
  ctc_result_if.source  result_o
);

  cfg_t   cfg;
  stage_t stage;
  logic   advance;

  ctc_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  ctc_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .tick_i    (tick_i),
    .advance_i (advance),
    .stage_o   (stage)
  );

  ctc_timer_core u_timer_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .stage_i   (stage),
    .advance_o (advance),
    .result_o  (result_o)
  );

endmodule
